// File: hw/rtl/hvac_bus_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// hvac_bus_frame_receiver_assert.svh
// Assertion macros shared by the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef HVAC_BUS_FRAME_RECEIVER_ASSERT_SVH
`define HVAC_BUS_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame receiver: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HBFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver: next-cycle check failed");

`endif

// File: hw/rtl/hbfr_pkg.sv
// ----------------------------------------------------------------------------
// hbfr_pkg
// Types and constants of the climate bus frame receiver.
// ----------------------------------------------------------------------------
package hbfr_pkg;

  localparam int unsigned FRAME_LEN = 14;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0] START_BYTE    = 8'h32;
  localparam logic [7:0] END_BYTE      = 8'h34;
  localparam logic [7:0] TEMP_OFFSET   = 8'd55;
  localparam logic [3:0] SWING_NIBBLE  = 4'hD;
  localparam logic [7:0] CMD_STATUS    = 8'h20;
  localparam logic [7:0] CMD_CAPACITY  = 8'h40;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [7:0]  OUTDOOR_RESET = 8'd200;

  // Item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTDOOR = 2'd1;

  typedef enum logic [2:0] {
    ST_STATUS   = 3'd0,
    ST_CAPACITY = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_BAD_SUM  = 3'd3,
    ST_NO_END   = 3'd4,
    ST_TIMEOUT  = 3'd5
  } status_t;

  typedef struct packed {
    status_t           status;
    logic              unit;
    logic signed [7:0] set_temp;
    logic signed [7:0] room_temp;
    logic signed [7:0] pipe_in_temp;
    logic signed [7:0] pipe_out_temp;
    logic [3:0]        fan_speed;
    logic              swing_on;
    logic              power_on;
    logic [5:0]        mode;
    logic [7:0]        capacity_tenths;
    logic [7:0]        delta_q;
  } result_t;

endpackage

// File: hw/rtl/hbfr_if.sv
// ----------------------------------------------------------------------------
// hbfr_in_if / hbfr_out_if
// Valid/ready channels for received requests and decoded results.
// ----------------------------------------------------------------------------
interface hbfr_in_if
  import hbfr_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface hbfr_out_if
  import hbfr_pkg::*;
;
  logic              valid;
  logic              ready;
  status_t           status;
  logic              unit;
  logic signed [7:0] set_temp;
  logic signed [7:0] room_temp;
  logic signed [7:0] pipe_in_temp;
  logic signed [7:0] pipe_out_temp;
  logic [3:0]        fan_speed;
  logic              swing_on;
  logic              power_on;
  logic [5:0]        mode;
  logic [7:0]        capacity_tenths;
  logic [7:0]        delta_q;

  modport source (
    output valid, output status, output unit, output set_temp, output room_temp,
    output pipe_in_temp, output pipe_out_temp, output fan_speed, output swing_on,
    output power_on, output mode, output capacity_tenths, output delta_q,
    input ready
  );
  modport sink (
    input valid, input status, input unit, input set_temp, input room_temp,
    input pipe_in_temp, input pipe_out_temp, input fan_speed, input swing_on,
    input power_on, input mode, input capacity_tenths, input delta_q,
    output ready
  );
endinterface

// File: hw/rtl/hvac_bus_frame_receiver.sv
// ----------------------------------------------------------------------------
// hvac_bus_frame_receiver
// Frame receiver for a two-wire climate bus. Each input request is either one
// received serial byte or one time tick. Outside a frame the start byte 0x32
// opens a frame of exactly 14 bytes; the last must be 0x34. The XOR of bytes
// 1 to 11 is checked against byte 12, and frames from indoor unit 0 or 1 to
// the programmed outdoor address are decoded into a status record (command
// 0x20) or a capacity record (command 0x40). Every closed frame, and every
// partial frame dropped after timeout_ticks idle ticks, yields one result;
// other requests yield none. The block takes one request every cycle: byte
// counting, checksum, storage and decode all settle combinationally between
// the frame state registers and the result register, and a two-entry output
// stage (result register plus skid) keeps input ready high while one result
// waits downstream. Input ready drops only when both entries are full.
// Registers: index 0 timeout_ticks (reset 500), index 1 outdoor_address
// (reset 200); write them only while the block is idle.
// ----------------------------------------------------------------------------
`include "hvac_bus_frame_receiver_assert.svh"

module hvac_bus_frame_receiver
  import hbfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  hbfr_in_if.sink               in_ch,
  hbfr_out_if.source            out_ch
);

  // Configuration
  logic [15:0] timeout_r;
  logic [7:0]  outdoor_r;

  // Frame state
  logic             in_frame_r,  in_frame_nxt;
  logic [CNT_W-1:0] byte_cnt_r,  byte_cnt_nxt;
  logic [7:0]       xor_r,       xor_nxt;
  logic [15:0]      idle_r,      idle_nxt;
  logic [7:0]       frame_r [FRAME_LEN];

  // Output stage
  logic    out_valid_r,  out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r,        out_nxt;
  result_t skid_r,       skid_nxt;

  logic             in_fire;
  logic [CNT_W-1:0] byte_idx;
  logic [15:0]      idle_inc;
  logic             res_valid;
  result_t          res;
  logic             out_free;
  logic             close_fire;

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Position of the incoming byte: outside a frame a start byte lands at zero.
  assign byte_idx = in_frame_r ? byte_cnt_r : '0;
  assign idle_inc = (idle_r != 16'hFFFF) ? idle_r + 16'd1 : idle_r;

  // --------------------------------------------------------------------------
  // Frame tracking and decode
  // --------------------------------------------------------------------------
  always_comb begin
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] cmd;
    logic       take_byte;

    in_frame_nxt = in_frame_r;
    byte_cnt_nxt = byte_cnt_r;
    xor_nxt      = xor_r;
    idle_nxt     = idle_r;
    res_valid    = 1'b0;
    res          = '0;
    src          = frame_r[1];
    dst          = frame_r[2];
    cmd          = frame_r[3];
    take_byte    = 1'b0;

    if (in_fire) begin
      if (in_ch.kind == KIND_TICK) begin
        // Count idle ticks only inside a frame; drop it on timeout.
        if (in_frame_r) begin
          idle_nxt = idle_inc;
          if (idle_inc >= timeout_r) begin
            in_frame_nxt = 1'b0;
            res_valid    = 1'b1;
            res.status   = ST_TIMEOUT;
          end
        end
      end else begin
        idle_nxt  = '0;
        take_byte = in_frame_r || (in_ch.rx_byte == START_BYTE);
      end
    end

    if (take_byte) begin
      in_frame_nxt = 1'b1;
      byte_cnt_nxt = byte_idx + 1'b1;
      if (byte_idx == '0) begin
        xor_nxt = '0;
      end else if (byte_idx <= CNT_W'(11)) begin
        xor_nxt = xor_r ^ in_ch.rx_byte;
      end

      // Close on the last byte of the frame.
      if (byte_idx == CNT_W'(FRAME_LEN - 1)) begin
        in_frame_nxt = 1'b0;
        res_valid    = 1'b1;
        if (in_ch.rx_byte != END_BYTE) begin
          res.status = ST_NO_END;
        end else if (xor_r != frame_r[12]) begin
          res.status = ST_BAD_SUM;
        end else if (src > 8'd1 || dst != outdoor_r) begin
          res.status = ST_IGNORED;
        end else if (cmd == CMD_STATUS) begin
          res.status        = ST_STATUS;
          res.unit          = src[0];
          res.set_temp      = $signed(frame_r[4] - TEMP_OFFSET);
          res.room_temp     = $signed(frame_r[5] - TEMP_OFFSET);
          res.pipe_in_temp  = $signed(frame_r[6] - TEMP_OFFSET);
          res.pipe_out_temp = $signed(frame_r[11] - TEMP_OFFSET);
          res.fan_speed     = frame_r[7][3:0];
          res.swing_on      = (frame_r[7][7:4] == SWING_NIBBLE);
          res.power_on      = frame_r[8][7];
          res.mode          = frame_r[8][5:0];
        end else if (cmd == CMD_CAPACITY) begin
          res.status          = ST_CAPACITY;
          res.unit            = src[0];
          res.capacity_tenths = frame_r[9];
          res.delta_q         = frame_r[11];
        end else begin
          res.status = ST_IGNORED;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: result register with one skid entry behind it
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        // Advance the waiting entry; no request is taken this cycle.
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = res_valid;
      end
    end else if (res_valid) begin
      // Hold the stalled result; park the new one in the skid.
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RESET;
      outdoor_r    <= OUTDOOR_RESET;
      in_frame_r   <= 1'b0;
      byte_cnt_r   <= '0;
      xor_r        <= '0;
      idle_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT: timeout_r <= cfg_wdata[15:0];
          REG_OUTDOOR: outdoor_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      in_frame_r   <= in_frame_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      xor_r        <= xor_nxt;
      idle_r       <= idle_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    if (in_fire && in_ch.kind == KIND_BYTE &&
        (in_frame_r || in_ch.rx_byte == START_BYTE)) begin
      frame_r[byte_idx] <= in_ch.rx_byte;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_r.status;
  assign out_ch.unit            = out_r.unit;
  assign out_ch.set_temp        = out_r.set_temp;
  assign out_ch.room_temp       = out_r.room_temp;
  assign out_ch.pipe_in_temp    = out_r.pipe_in_temp;
  assign out_ch.pipe_out_temp   = out_r.pipe_out_temp;
  assign out_ch.fan_speed       = out_r.fan_speed;
  assign out_ch.swing_on        = out_r.swing_on;
  assign out_ch.power_on        = out_r.power_on;
  assign out_ch.mode            = out_r.mode;
  assign out_ch.capacity_tenths = out_r.capacity_tenths;
  assign out_ch.delta_q         = out_r.delta_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  assign close_fire = in_fire && in_ch.kind == KIND_BYTE && in_frame_r &&
                      byte_cnt_r == CNT_W'(FRAME_LEN - 1);

  // The skid only fills behind a held result.
  `HBFR_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  // The last byte of a frame always closes it.
  `HBFR_ASSERT_NEXT(a_last_byte_closes, clk, rst_n, close_fire, !in_frame_r)
  // A closing request always leaves a result waiting.
  `HBFR_ASSERT_NEXT(a_close_gives_result, clk, rst_n, res_valid, out_valid_r)
  // Inside a frame the byte position never reaches the frame length.
  `HBFR_ASSERT_IMPL(a_count_in_range, clk, rst_n, in_frame_r, byte_cnt_r < CNT_W'(FRAME_LEN))

endmodule

// File: sim/tb_hvac_bus_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_hvac_bus_frame_receiver
// Self-checking bench for the climate bus frame receiver. A table of directed
// frames covers decoded records, field extremes, every drop reason and every
// register. Random phases with new register settings follow. Most random
// requests form well-built frames with random content, mixed with noise,
// broken frames and idle ticks. A frame decoder inside the bench tracks the
// receiver and predicts each record, and every record that leaves the block
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_hvac_bus_frame_receiver
  import hbfr_pkg::*;
;

  // Unused register slots; writes there must leave both registers alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 4;     // result register plus skid, with margin
  localparam int DRAIN_CYCLES   = 8;
  localparam int STALL_LIMIT    = 2000;  // cycles with no request, record or write
  localparam int RAND_PHASES    = 6;
  localparam int LIVE_PER_PHASE = 90;    // requests that reach frame state
  localparam int MAX_REPORTS    = 10;

  // One directed row: an optional register write, then the first nbytes bytes
  // of body, then a run of ticks. Rows whose outcome is plain to see carry a
  // pinned status; the record then must be that status with all fields zero.
  typedef struct packed {
    logic                  do_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    logic [3:0]            nbytes;
    logic [0:13][7:0]      body;
    logic                  fix_sum;
    logic [15:0]           ticks;
    logic                  pinned;
    status_t               pin_status;
  } stim_row_t;

  localparam int DIR_ROWS = 18;
  localparam stim_row_t DIR_TBL [DIR_ROWS] = '{
    // Noise outside a frame, then ticks outside a frame: nothing comes out.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd3,
      112'h00_FF_34_00_00_00_00_00_00_00_00_00_00_00, 1'b0, 16'd2, 1'b0, ST_STATUS},
    // Status record, unit 0, reset address: temps wrap at 0x00, 0xFF, 55,
    // swing nibble with fan 15, power with mode 63, start byte as data.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd14,
      112'h32_00_C8_20_00_FF_37_DF_BF_FF_32_B6_00_34, 1'b1, 16'd0, 1'b0, ST_STATUS},
    // Status record, unit 1: temp -128 and -1, no swing, power off.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd14,
      112'h32_01_C8_20_B7_36_80_C0_40_00_00_37_00_34, 1'b1, 16'd0, 1'b0, ST_STATUS},
    // Capacity record, unit 1, top values.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd14,
      112'h32_01_C8_40_5A_A5_0F_F0_55_FF_AA_FF_00_34, 1'b1, 16'd0, 1'b0, ST_STATUS},
    // Capacity record, unit 0, all zero.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd14,
      112'h32_00_C8_40_00_00_00_00_00_00_00_00_00_34, 1'b1, 16'd0, 1'b0, ST_STATUS},
    // Source beyond the indoor units.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd14,
      112'h32_FF_C8_20_11_22_33_44_55_66_77_88_00_34, 1'b1, 16'd0, 1'b1, ST_IGNORED},
    // Wrong destination.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd14,
      112'h32_00_C7_20_11_22_33_44_55_66_77_88_00_34, 1'b1, 16'd0, 1'b1, ST_IGNORED},
    // Unknown command.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd14,
      112'h32_01_C8_21_11_22_33_44_55_66_77_88_00_34, 1'b1, 16'd0, 1'b1, ST_IGNORED},
    // Checksum byte 0x00 against a sum of 0xE8.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd14,
      112'h32_00_C8_20_00_00_00_00_00_00_00_00_00_34, 1'b0, 16'd0, 1'b1, ST_BAD_SUM},
    // Start byte where the end byte belongs; it must not open a new frame.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd14,
      112'h32_00_C8_20_11_22_33_44_55_66_77_88_00_32, 1'b1, 16'd0, 1'b1, ST_NO_END},
    // Partial frame left for the reset timeout of 500 ticks.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd5,
      112'h32_00_C8_20_11_00_00_00_00_00_00_00_00_00, 1'b0, 16'd500, 1'b1, ST_TIMEOUT},
    // Zero timeout drops on the first tick; later ticks fall outside a frame.
    '{1'b1, REG_TIMEOUT, 16'd0, 4'd3,
      112'h32_01_C8_00_00_00_00_00_00_00_00_00_00_00, 1'b0, 16'd3, 1'b1, ST_TIMEOUT},
    // Outdoor address 0.
    '{1'b1, REG_OUTDOOR, 16'h0000, 4'd14,
      112'h32_01_00_20_9C_63_E1_D5_85_3C_C3_7E_00_34, 1'b1, 16'd0, 1'b0, ST_STATUS},
    // Outdoor address 255.
    '{1'b1, REG_OUTDOOR, 16'h00FF, 4'd14,
      112'h32_00_FF_40_12_34_56_78_9A_BC_DE_F0_00_34, 1'b1, 16'd0, 1'b0, ST_STATUS},
    // Spare index with all ones: timeout must still be zero.
    '{1'b1, REG_SPARE_LO, 16'hFFFF, 4'd2,
      112'h32_00_00_00_00_00_00_00_00_00_00_00_00_00, 1'b0, 16'd1, 1'b1, ST_TIMEOUT},
    // Spare index with the reset address: address must still be 255.
    '{1'b1, REG_SPARE_HI, 16'h00C8, 4'd14,
      112'h32_00_C8_20_11_22_33_44_55_66_77_88_00_34, 1'b1, 16'd0, 1'b1, ST_IGNORED},
    // Largest timeout: ticks far short of it leave the frame open.
    '{1'b1, REG_TIMEOUT, 16'hFFFF, 4'd4,
      112'h32_01_C8_40_00_00_00_00_00_00_00_00_00_00, 1'b0, 16'd40, 1'b0, ST_STATUS},
    // Finish that open frame with ten more bytes and a wrong end byte.
    '{1'b0, REG_TIMEOUT, 16'd0, 4'd10,
      112'h11_22_33_44_55_66_77_88_00_00_00_00_00_00, 1'b0, 16'd0, 1'b1, ST_NO_END}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hbfr_in_if  in_ch ();
  hbfr_out_if out_ch ();

  hvac_bus_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Frame decoder copy: register values and receive state.
  logic [15:0] tmo_limit;
  logic [7:0]  own_addr;
  logic        rx_open;
  logic [3:0]  rx_pos;
  logic [7:0]  rx_buf [FRAME_LEN];
  logic [7:0]  rx_sum;
  logic [15:0] quiet_ticks;

  result_t awaited_records [$];

  // Pinned status for the current directed row, used by its one record.
  logic    pin_armed = 1'b0;
  status_t pin_status = ST_STATUS;

  logic steady = 1'b0;   // both sides run without gaps while set

  int n_in, n_tick, n_live, n_out, n_cfg, n_miss, stall_cycles;
  int n_by_status [8];

  function automatic logic [7:0] frame_sum(input logic [0:13][7:0] fb);
    logic [7:0] s;
    s = '0;
    for (int i = 1; i <= 11; i++) s ^= fb[i];
    return s;
  endfunction

  // Advance the decoder copy by one request. hit flags a record in rec;
  // live flags a request that touched frame state (not dropped outright).
  function automatic void decode_bus_item(input logic k, input logic [7:0] b,
                                          output result_t rec, output logic hit,
                                          output logic live);
    rec  = '0;
    hit  = 1'b0;
    live = 1'b0;
    if (k == KIND_TICK) begin
      if (!rx_open) return;
      live = 1'b1;
      if (quiet_ticks != 16'hFFFF) quiet_ticks++;
      if (quiet_ticks >= tmo_limit) begin
        rx_open    = 1'b0;
        rec.status = ST_TIMEOUT;
        hit        = 1'b1;
      end
      return;
    end
    quiet_ticks = '0;
    if (!rx_open) begin
      if (b != START_BYTE) return;
      rx_open = 1'b1;
      rx_pos  = '0;
      rx_sum  = '0;
    end
    live = 1'b1;
    rx_buf[rx_pos] = b;
    if (rx_pos >= 1 && rx_pos <= 11) rx_sum ^= b;
    rx_pos++;
    if (rx_pos < FRAME_LEN) return;
    // Frame closes on its 14th byte whatever that byte is.
    rx_open = 1'b0;
    hit     = 1'b1;
    if (b != END_BYTE) begin
      rec.status = ST_NO_END;
    end else if (rx_sum != rx_buf[12]) begin
      rec.status = ST_BAD_SUM;
    end else if (rx_buf[1] > 8'd1 || rx_buf[2] != own_addr) begin
      rec.status = ST_IGNORED;
    end else if (rx_buf[3] == CMD_STATUS) begin
      rec.status        = ST_STATUS;
      rec.unit          = rx_buf[1][0];
      rec.set_temp      = rx_buf[4] - TEMP_OFFSET;
      rec.room_temp     = rx_buf[5] - TEMP_OFFSET;
      rec.pipe_in_temp  = rx_buf[6] - TEMP_OFFSET;
      rec.pipe_out_temp = rx_buf[11] - TEMP_OFFSET;
      rec.fan_speed     = rx_buf[7][3:0];
      rec.swing_on      = (rx_buf[7][7:4] == SWING_NIBBLE);
      rec.power_on      = rx_buf[8][7];
      rec.mode          = rx_buf[8][5:0];
    end else if (rx_buf[3] == CMD_CAPACITY) begin
      rec.status          = ST_CAPACITY;
      rec.unit            = rx_buf[1][0];
      rec.capacity_tenths = rx_buf[9];
      rec.delta_q         = rx_buf[11];
    end else begin
      rec.status = ST_IGNORED;
    end
  endfunction

  task automatic note_miss(input string what, input logic [15:0] want_v,
                           input logic [15:0] got_v);
    if (n_miss < MAX_REPORTS)
      $display("MISMATCH %s: expected %0h, got %0h (record %0d)",
               what, want_v, got_v, n_out);
    n_miss++;
  endtask

  // Monitor: update the decoder copy on accepted writes and requests, check
  // each record that leaves, and watch for a stuck run. Requests are handled
  // before records so that a record can never overtake its prediction.
  always @(posedge clk) begin
    result_t want, got;
    logic    hit, live;
    if (!rst_n) begin
      tmo_limit    = TIMEOUT_RESET;
      own_addr     = OUTDOOR_RESET;
      rx_open      = 1'b0;
      rx_pos       = '0;
      rx_sum       = '0;
      quiet_ticks  = '0;
      stall_cycles = 0;
      for (int i = 0; i < FRAME_LEN; i++) rx_buf[i] = '0;
    end else begin
      stall_cycles++;
      if (cfg_we) begin
        // Drop writes to spare indexes, as the block does.
        if (cfg_index == REG_TIMEOUT) tmo_limit = cfg_wdata;
        else if (cfg_index == REG_OUTDOOR) own_addr = cfg_wdata[7:0];
        n_cfg++;
        stall_cycles = 0;
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_bus_item(in_ch.kind, in_ch.rx_byte, want, hit, live);
        n_in++;
        if (in_ch.kind == KIND_TICK) n_tick++;
        if (live) n_live++;
        if (hit) begin
          if (pin_armed) begin
            want        = '0;
            want.status = pin_status;
            pin_armed   = 1'b0;
          end
          awaited_records.insert(awaited_records.size(), want);
        end
        stall_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status          = out_ch.status;
        got.unit            = out_ch.unit;
        got.set_temp        = out_ch.set_temp;
        got.room_temp       = out_ch.room_temp;
        got.pipe_in_temp    = out_ch.pipe_in_temp;
        got.pipe_out_temp   = out_ch.pipe_out_temp;
        got.fan_speed       = out_ch.fan_speed;
        got.swing_on        = out_ch.swing_on;
        got.power_on        = out_ch.power_on;
        got.mode            = out_ch.mode;
        got.capacity_tenths = out_ch.capacity_tenths;
        got.delta_q         = out_ch.delta_q;
        if (awaited_records.size() == 0) begin
          note_miss("record with none awaited, status", 16'h0, 16'(got.status));
        end else begin
          want = awaited_records.pop_front();
          if (got.status !== want.status)
            note_miss("status", 16'(want.status), 16'(got.status));
          if (got.unit !== want.unit)
            note_miss("unit", 16'(want.unit), 16'(got.unit));
          if (got.set_temp !== want.set_temp)
            note_miss("set_temp", 16'(want.set_temp), 16'(got.set_temp));
          if (got.room_temp !== want.room_temp)
            note_miss("room_temp", 16'(want.room_temp), 16'(got.room_temp));
          if (got.pipe_in_temp !== want.pipe_in_temp)
            note_miss("pipe_in_temp", 16'(want.pipe_in_temp), 16'(got.pipe_in_temp));
          if (got.pipe_out_temp !== want.pipe_out_temp)
            note_miss("pipe_out_temp", 16'(want.pipe_out_temp), 16'(got.pipe_out_temp));
          if (got.fan_speed !== want.fan_speed)
            note_miss("fan_speed", 16'(want.fan_speed), 16'(got.fan_speed));
          if (got.swing_on !== want.swing_on)
            note_miss("swing_on", 16'(want.swing_on), 16'(got.swing_on));
          if (got.power_on !== want.power_on)
            note_miss("power_on", 16'(want.power_on), 16'(got.power_on));
          if (got.mode !== want.mode)
            note_miss("mode", 16'(want.mode), 16'(got.mode));
          if (got.capacity_tenths !== want.capacity_tenths)
            note_miss("capacity_tenths", 16'(want.capacity_tenths),
                      16'(got.capacity_tenths));
          if (got.delta_q !== want.delta_q)
            note_miss("delta_q", 16'(want.delta_q), 16'(got.delta_q));
        end
        if (!$isunknown(got.status)) n_by_status[got.status]++;
        n_out++;
        stall_cycles = 0;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles, %0d records awaited",
                 stall_cycles, awaited_records.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver side: drop ready at random, with a chance of about 31 percent, unless steady.
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 31);
  end

  // Present one request and hold it until accepted. Leave valid high on
  // return so a following request can go out back to back; any other step
  // must lower valid first.
  task automatic send_item(input logic k, input logic [7:0] b);
    if (!steady) begin
      while ($urandom_range(99) < 31) begin
        in_ch.valid   <= 1'b0;
        in_ch.kind    <= 1'($urandom);
        in_ch.rx_byte <= 8'($urandom);
        @(negedge clk);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Hold the sender until every awaited record has come, then wait extra
  // cycles for anything still in flight.
  task automatic settle(input int extra);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (awaited_records.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-built frames with random content; some carry a bad sum, a
  // wrong end byte, foreign addresses or commands, ticks between bytes, or
  // stop early and get idle ticks that run out the timeout where it is small.
  task automatic send_random_frame();
    logic [0:13][7:0] fb;
    int len, n;
    fb[0] = START_BYTE;
    fb[1] = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1));
    fb[2] = ($urandom_range(99) < 85) ? own_addr : 8'($urandom);
    case ($urandom_range(9))
      0:       fb[3] = 8'($urandom);
      1, 2, 3, 4: fb[3] = CMD_STATUS;
      default: fb[3] = CMD_CAPACITY;
    endcase
    for (int i = 4; i <= 11; i++) fb[i] = 8'($urandom);
    fb[12] = frame_sum(fb);
    if ($urandom_range(9) == 0) fb[12] ^= 8'($urandom_range(255, 1));
    fb[13] = ($urandom_range(9) == 0) ? 8'($urandom) : END_BYTE;
    len = ($urandom_range(99) < 8) ? $urandom_range(13, 1) : 14;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(99) < 12) begin
        n = $urandom_range(3, 1);
        repeat (n) send_item(KIND_TICK, 8'($urandom));
      end
      send_item(KIND_BYTE, fb[i]);
    end
    if (len < 14) begin
      // Cut short: run the idle count out where the limit is small.
      n = (tmo_limit <= 16'd64) ? int'(tmo_limit) + 1 : $urandom_range(5, 1);
      repeat (n) send_item(KIND_TICK, 8'($urandom));
    end
  endtask

  initial begin
    stim_row_t        row;
    logic [0:13][7:0] fb;
    logic [15:0]      t_val;
    logic [7:0]       a_val;
    int               target;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = KIND_BYTE;
    in_ch.rx_byte = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, starting from the reset register values.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TBL[r];
      if (row.do_cfg) begin
        settle(SETTLE_CYCLES);
        write_reg(row.cfg_idx, row.cfg_val);
      end
      pin_status = row.pin_status;
      pin_armed  = row.pinned;
      fb = row.body;
      if (row.fix_sum) fb[12] = frame_sum(fb);
      for (int k = 0; k < row.nbytes; k++) send_item(KIND_BYTE, fb[k]);
      for (int k = 0; k < row.ticks; k++) send_item(KIND_TICK, 8'($urandom));
    end

    // Random phases, each with its own register setting.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       begin t_val = 16'd1;                    a_val = 8'hFF;          end
        1:       begin t_val = 16'($urandom_range(12, 2)); a_val = 8'($urandom); end
        2:       begin t_val = 16'd0;                    a_val = 8'h00;          end
        3:       begin t_val = 16'($urandom_range(60, 13)); a_val = OUTDOOR_RESET; end
        4:       begin t_val = 16'hFFFF;                 a_val = 8'($urandom);   end
        default: begin t_val = 16'($urandom_range(30, 2)); a_val = 8'($urandom); end
      endcase
      settle(SETTLE_CYCLES);
      write_reg(REG_TIMEOUT, t_val);
      write_reg(REG_OUTDOOR, {8'h00, a_val});
      steady = (phase == 3);
      target = n_live + LIVE_PER_PHASE;
      while (n_live < target) begin
        if ($urandom_range(99) < 3) settle(0);
        if ($urandom_range(99) < 75) begin
          send_random_frame();
        end else begin
          repeat ($urandom_range(6, 1)) send_item(1'($urandom), 8'($urandom));
        end
      end
    end
    steady = 1'b0;

    settle(DRAIN_CYCLES);
    $display("Run covered %0d requests (%0d ticks, %0d in frames), %0d register writes.",
             n_in, n_tick, n_live, n_cfg);
    $display("Records by status 0..5: %0d %0d %0d %0d %0d %0d; %0d mismatches.",
             n_by_status[ST_STATUS], n_by_status[ST_CAPACITY], n_by_status[ST_IGNORED],
             n_by_status[ST_BAD_SUM], n_by_status[ST_NO_END], n_by_status[ST_TIMEOUT],
             n_miss);
    if (n_miss == 0 && awaited_records.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
